// ----- hdl/word_frequency_top_k_assert.svh -----
// Assertion helpers used by the datapath file of the word frequency block.
`ifndef WORD_FREQUENCY_TOP_K_ASSERT_SVH
`define WORD_FREQUENCY_TOP_K_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WFTK_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("wftk assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WFTK_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("wftk assertion failed");

`endif

// ----- hdl/wftk_pkg.sv -----
`default_nettype none

package wftk_pkg;

    localparam int WORD_BYTES_DEF     = 64;
    localparam int FILE_ENTRIES_DEF   = 256;
    localparam int GLOBAL_ENTRIES_DEF = 64;
    localparam int MAX_K_DEF          = 16;

    localparam int COUNT_W = 32;
    localparam int TOPK_W  = 5;
    localparam logic [TOPK_W-1:0] TOP_K_RESET = 5'd5;

    // Action codes of an input beat.
    localparam logic [1:0] ACT_TEXT   = 2'd0;
    localparam logic [1:0] ACT_EOF    = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] text_byte;
        logic [3:0] read_rank;
        logic [5:0] read_pos;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  entry_count;
        logic [31:0] word_total;
        logic [7:0]  word_char;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_LK_RD,
        S_LK_CMP,
        S_LK_MISS,
        S_FR_INIT,
        S_FR_START,
        S_FR_RD,
        S_FR_CMP,
        S_GA_RD,
        S_GA_CMP,
        S_GA_MISS,
        S_GR_INIT,
        S_GR_START,
        S_GR_RD,
        S_GR_CMP,
        S_GR_SEL,
        S_RD_DATA,
        S_EMIT
    } wftk_state_t;

    typedef struct packed {
        logic take;
        logic tok_append;
        logic tok_clear;
        logic f_rd;
        logic f_idx_clr;
        logic f_idx_inc;
        logic f_hit_wr;
        logic f_add;
        logic f_used_clr;
        logic g_rd_scan;
        logic g_rd_rank;
        logic g_idx_clr;
        logic g_idx_inc;
        logic g_hit_wr;
        logic g_add;
        logic best_clr;
        logic best_f;
        logic best_g;
        logic rank_init_f;
        logic rank_init_g;
        logic rank_next;
        logic order_wr;
        logic ranked_set;
        logic res_read;
        logic res_plain;
        logic res_empty;
        logic out_load;
    } wftk_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       tok_empty;
        logic       is_space;
        logic       f_scan_end;
        logic       g_scan_end;
        logic       f_match;
        logic       g_match;
        logic       r_done;
        logic       rank_empty;
        logic       out_free;
    } wftk_stat_t;

endpackage

`default_nettype wire

// ----- hdl/word_frequency_top_k.sv -----
// Channel  | Signals                        | Beat taken when
// ---------+--------------------------------+----------------------------
// input    | in_valid, in_stall, in_item    | in_valid && !in_stall
// result   | out_valid, out_stall, out_item | out_valid && !out_stall
// config   | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
// A text byte that extends a word is appended to the token; a byte that ends
// a word starts a row-by-row search of the file table (U words).
// End of file makes up to K picks: each scans the file table and then
// searches the global table (G words) through one read port.
// Finish makes up to K picks over the global table.
// Reset clears all control state at once; there is no clearing pass.
// A finished result waits in the output register while out_stall is high.
`default_nettype none

module word_frequency_top_k #(
    parameter int WORD_BYTES     = wftk_pkg::WORD_BYTES_DEF,
    parameter int FILE_ENTRIES   = wftk_pkg::FILE_ENTRIES_DEF,
    parameter int GLOBAL_ENTRIES = wftk_pkg::GLOBAL_ENTRIES_DEF,
    parameter int MAX_K          = wftk_pkg::MAX_K_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  wftk_pkg::in_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output wftk_pkg::out_item_t         out_item,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [wftk_pkg::TOPK_W-1:0] cfg_data
);

    wftk_pkg::wftk_cmd_t  cmd;
    wftk_pkg::wftk_stat_t stat;
    logic                 cfg_wr;

    // The top_k register can take a beat in any cycle; writes are expected
    // only while the block is idle.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // The controller sequences each input beat through lookup, ranking and
    // merge steps; the datapath holds the tables, token and result register.
    wftk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    wftk_dp #(
        .WORD_BYTES     (WORD_BYTES),
        .FILE_ENTRIES   (FILE_ENTRIES),
        .GLOBAL_ENTRIES (GLOBAL_ENTRIES),
        .MAX_K          (MAX_K)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_wr    (cfg_wr),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// ----- hdl/wftk_ctrl.sv -----
`default_nettype none

module wftk_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  wftk_pkg::wftk_stat_t  stat,
    output wftk_pkg::wftk_cmd_t   cmd
);

    wftk_pkg::wftk_state_t state_reg;
    wftk_pkg::wftk_state_t state_next;
    wftk_pkg::wftk_state_t after_lookup;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wftk_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A finished word during end of file continues into the file ranking.
    assign after_lookup = (stat.action == wftk_pkg::ACT_EOF) ? wftk_pkg::S_FR_INIT
                                                              : wftk_pkg::S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wftk_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = wftk_pkg::S_DISPATCH;
                end
            end
            wftk_pkg::S_DISPATCH:
            begin
                unique case (stat.action)
                    wftk_pkg::ACT_TEXT:
                    begin
                        if (stat.is_space && !stat.tok_empty)
                        begin
                            state_next = wftk_pkg::S_LK_RD;
                        end
                        else
                        begin
                            state_next = wftk_pkg::S_IDLE;
                        end
                    end
                    wftk_pkg::ACT_EOF:
                    begin
                        state_next = stat.tok_empty ? wftk_pkg::S_FR_INIT : wftk_pkg::S_LK_RD;
                    end
                    wftk_pkg::ACT_FINISH:
                    begin
                        state_next = wftk_pkg::S_GR_INIT;
                    end
                    wftk_pkg::ACT_READ:
                    begin
                        state_next = stat.rank_empty ? wftk_pkg::S_EMIT : wftk_pkg::S_RD_DATA;
                    end
                    default:
                    begin
                        state_next = wftk_pkg::S_IDLE;
                    end
                endcase
            end
            wftk_pkg::S_LK_RD:
            begin
                state_next = stat.f_scan_end ? wftk_pkg::S_LK_MISS : wftk_pkg::S_LK_CMP;
            end
            wftk_pkg::S_LK_CMP:
            begin
                state_next = stat.f_match ? after_lookup : wftk_pkg::S_LK_RD;
            end
            wftk_pkg::S_LK_MISS:
            begin
                state_next = after_lookup;
            end
            wftk_pkg::S_FR_INIT:
            begin
                state_next = wftk_pkg::S_FR_START;
            end
            wftk_pkg::S_FR_START:
            begin
                state_next = stat.r_done ? wftk_pkg::S_IDLE : wftk_pkg::S_FR_RD;
            end
            wftk_pkg::S_FR_RD:
            begin
                state_next = stat.f_scan_end ? wftk_pkg::S_GA_RD : wftk_pkg::S_FR_CMP;
            end
            wftk_pkg::S_FR_CMP:
            begin
                state_next = wftk_pkg::S_FR_RD;
            end
            wftk_pkg::S_GA_RD:
            begin
                state_next = stat.g_scan_end ? wftk_pkg::S_GA_MISS : wftk_pkg::S_GA_CMP;
            end
            wftk_pkg::S_GA_CMP:
            begin
                state_next = stat.g_match ? wftk_pkg::S_FR_START : wftk_pkg::S_GA_RD;
            end
            wftk_pkg::S_GA_MISS:
            begin
                state_next = wftk_pkg::S_FR_START;
            end
            wftk_pkg::S_GR_INIT:
            begin
                state_next = wftk_pkg::S_GR_START;
            end
            wftk_pkg::S_GR_START:
            begin
                state_next = stat.r_done ? wftk_pkg::S_EMIT : wftk_pkg::S_GR_RD;
            end
            wftk_pkg::S_GR_RD:
            begin
                state_next = stat.g_scan_end ? wftk_pkg::S_GR_SEL : wftk_pkg::S_GR_CMP;
            end
            wftk_pkg::S_GR_CMP:
            begin
                state_next = wftk_pkg::S_GR_RD;
            end
            wftk_pkg::S_GR_SEL:
            begin
                state_next = wftk_pkg::S_GR_START;
            end
            wftk_pkg::S_RD_DATA:
            begin
                state_next = wftk_pkg::S_EMIT;
            end
            wftk_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = wftk_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wftk_pkg::S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != wftk_pkg::S_IDLE);

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            wftk_pkg::S_IDLE:
            begin
                cmd.take = in_valid;
            end
            wftk_pkg::S_DISPATCH:
            begin
                unique case (stat.action)
                    wftk_pkg::ACT_TEXT:
                    begin
                        cmd.tok_append = !stat.is_space;
                        cmd.f_idx_clr  = stat.is_space;
                    end
                    wftk_pkg::ACT_EOF:
                    begin
                        cmd.f_idx_clr = 1'b1;
                    end
                    wftk_pkg::ACT_FINISH:
                    begin
                        cmd.best_clr = 1'b1;
                    end
                    wftk_pkg::ACT_READ:
                    begin
                        cmd.res_empty = stat.rank_empty;
                        cmd.g_rd_rank = !stat.rank_empty;
                    end
                    default:
                    begin
                        cmd.best_clr = 1'b0;
                    end
                endcase
            end
            wftk_pkg::S_LK_RD:
            begin
                cmd.f_rd = !stat.f_scan_end;
            end
            wftk_pkg::S_LK_CMP:
            begin
                cmd.f_hit_wr  = stat.f_match;
                cmd.tok_clear = stat.f_match;
                cmd.f_idx_inc = !stat.f_match;
            end
            wftk_pkg::S_LK_MISS:
            begin
                cmd.f_add     = 1'b1;
                cmd.tok_clear = 1'b1;
            end
            wftk_pkg::S_FR_INIT:
            begin
                cmd.rank_init_f = 1'b1;
            end
            wftk_pkg::S_FR_START:
            begin
                cmd.f_used_clr = stat.r_done;
                cmd.f_idx_clr  = !stat.r_done;
                cmd.best_clr   = !stat.r_done;
            end
            wftk_pkg::S_FR_RD:
            begin
                cmd.f_rd      = !stat.f_scan_end;
                cmd.g_idx_clr = stat.f_scan_end;
            end
            wftk_pkg::S_FR_CMP:
            begin
                cmd.best_f    = 1'b1;
                cmd.f_idx_inc = 1'b1;
            end
            wftk_pkg::S_GA_RD:
            begin
                cmd.g_rd_scan = !stat.g_scan_end;
            end
            wftk_pkg::S_GA_CMP:
            begin
                cmd.g_hit_wr  = stat.g_match;
                cmd.rank_next = stat.g_match;
                cmd.g_idx_inc = !stat.g_match;
            end
            wftk_pkg::S_GA_MISS:
            begin
                cmd.g_add     = 1'b1;
                cmd.rank_next = 1'b1;
            end
            wftk_pkg::S_GR_INIT:
            begin
                cmd.rank_init_g = 1'b1;
            end
            wftk_pkg::S_GR_START:
            begin
                cmd.ranked_set = stat.r_done;
                cmd.res_plain  = stat.r_done;
                cmd.g_idx_clr  = !stat.r_done;
                cmd.best_clr   = !stat.r_done;
            end
            wftk_pkg::S_GR_RD:
            begin
                cmd.g_rd_scan = !stat.g_scan_end;
            end
            wftk_pkg::S_GR_CMP:
            begin
                cmd.best_g    = 1'b1;
                cmd.g_idx_inc = 1'b1;
            end
            wftk_pkg::S_GR_SEL:
            begin
                cmd.order_wr  = 1'b1;
                cmd.rank_next = 1'b1;
            end
            wftk_pkg::S_RD_DATA:
            begin
                cmd.res_read = 1'b1;
            end
            wftk_pkg::S_EMIT:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                cmd.take = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/wftk_dp.sv -----
`default_nettype none

`include "word_frequency_top_k_assert.svh"

module wftk_dp #(
    parameter int WORD_BYTES     = wftk_pkg::WORD_BYTES_DEF,
    parameter int FILE_ENTRIES   = wftk_pkg::FILE_ENTRIES_DEF,
    parameter int GLOBAL_ENTRIES = wftk_pkg::GLOBAL_ENTRIES_DEF,
    parameter int MAX_K          = wftk_pkg::MAX_K_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wftk_pkg::in_item_t          in_item,
    input  logic                        cfg_wr,
    input  logic [wftk_pkg::TOPK_W-1:0] cfg_data,
    input  logic                        out_stall,
    output logic                        out_valid,
    output wftk_pkg::out_item_t         out_item,
    input  wftk_pkg::wftk_cmd_t         cmd,
    output wftk_pkg::wftk_stat_t        stat
);

    localparam int WW  = WORD_BYTES * 8;
    localparam int CW  = wftk_pkg::COUNT_W;
    localparam int RW  = WW + CW;
    localparam int LW  = $clog2(WORD_BYTES);
    localparam int FAW = $clog2(FILE_ENTRIES);
    localparam int FUW = $clog2(FILE_ENTRIES + 1);
    localparam int GAW = $clog2(GLOBAL_ENTRIES);
    localparam int GUW = $clog2(GLOBAL_ENTRIES + 1);
    localparam int KW  = $clog2(MAX_K + 1);
    localparam int KI  = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    // Words are stored with their first byte in the top bits, so an unsigned
    // compare of two padded words gives the byte-wise order.
    function automatic logic ahead(input logic [CW-1:0] ca, input logic [WW-1:0] wa,
                                   input logic [CW-1:0] cb, input logic [WW-1:0] wb);
        return (ca > cb) || ((ca == cb) && (wa < wb));
    endfunction

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    wftk_pkg::in_item_t         item_reg;
    logic [wftk_pkg::TOPK_W-1:0] topk_reg;
    logic [WW-1:0]              tok_reg;
    logic [LW-1:0]              tok_len_reg;
    logic [FUW-1:0]             file_used_reg;
    logic [FUW-1:0]             fidx_reg;
    logic [GUW-1:0]             glob_used_reg;
    logic [GUW-1:0]             gidx_reg;
    logic                       ovf_reg;
    logic                       best_valid_reg;
    logic [WW-1:0]              best_word_reg;
    logic [CW-1:0]              best_cnt_reg;
    logic [GAW-1:0]             best_gidx_reg;
    logic                       prev_valid_reg;
    logic [WW-1:0]              prev_word_reg;
    logic [CW-1:0]              prev_cnt_reg;
    logic [KW-1:0]              r_reg;
    logic [KW-1:0]              n_reg;
    logic [KW-1:0]              ranked_total_reg;
    logic [GAW-1:0]             order_reg [MAX_K];
    logic [1:0]                 res_status_reg;
    logic [CW-1:0]              res_total_reg;
    logic [7:0]                 res_char_reg;
    wftk_pkg::out_item_t        out_reg;
    logic                       out_valid_reg;

    logic [RW-1:0]  fmem [FILE_ENTRIES];
    logic [RW-1:0]  gmem [GLOBAL_ENTRIES];
    logic [RW-1:0]  f_row_reg;
    logic [RW-1:0]  g_row_reg;

    logic [WW-1:0]  f_word;
    logic [CW-1:0]  f_cnt;
    logic [WW-1:0]  g_word;
    logic [CW-1:0]  g_cnt;
    logic           f_full;
    logic           g_full;
    logic           f_wr_en;
    logic [FAW-1:0] f_wr_addr;
    logic [RW-1:0]  f_wr_data;
    logic           g_wr_en;
    logic [GAW-1:0] g_wr_addr;
    logic [RW-1:0]  g_wr_data;
    logic [GAW-1:0] g_rd_addr;
    logic [KI-1:0]  rank_idx;
    logic [WW-1:0]  cand_word;
    logic [CW-1:0]  cand_cnt;
    logic           cand_take;
    logic [7:0]     sel_char;
    logic [7:0]     folded;
    logic [KW-1:0]  n_file;
    logic [KW-1:0]  n_glob;

    assign f_word = f_row_reg[RW-1 -: WW];
    assign f_cnt  = f_row_reg[CW-1:0];
    assign g_word = g_row_reg[RW-1 -: WW];
    assign g_cnt  = g_row_reg[CW-1:0];
    assign f_full = (file_used_reg == FUW'(FILE_ENTRIES));
    assign g_full = (glob_used_reg == GUW'(GLOBAL_ENTRIES));
    assign rank_idx = KI'(item_reg.read_rank);

    // File table: one row per word, the padded word above its count.
    assign f_wr_en   = cmd.f_hit_wr || (cmd.f_add && !f_full);
    assign f_wr_addr = cmd.f_hit_wr ? fidx_reg[FAW-1:0] : file_used_reg[FAW-1:0];
    assign f_wr_data = cmd.f_hit_wr ? {f_word, sat_add(f_cnt, CW'(1))} : {tok_reg, CW'(1)};

    always_ff @(posedge clk)
    begin
        if (f_wr_en)
        begin
            fmem[f_wr_addr] <= f_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.f_rd)
        begin
            f_row_reg <= fmem[fidx_reg[FAW-1:0]];
        end
    end

    // Global table, read either while scanning or at a ranked index.
    assign g_wr_en   = cmd.g_hit_wr || (cmd.g_add && !g_full);
    assign g_wr_addr = cmd.g_hit_wr ? gidx_reg[GAW-1:0] : glob_used_reg[GAW-1:0];
    assign g_wr_data = cmd.g_hit_wr ? {g_word, sat_add(g_cnt, best_cnt_reg)}
                                    : {best_word_reg, best_cnt_reg};
    assign g_rd_addr = cmd.g_rd_rank ? order_reg[rank_idx] : gidx_reg[GAW-1:0];

    always_ff @(posedge clk)
    begin
        if (g_wr_en)
        begin
            gmem[g_wr_addr] <= g_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.g_rd_scan || cmd.g_rd_rank)
        begin
            g_row_reg <= gmem[g_rd_addr];
        end
    end

    // Candidate for the next rank: it must stand behind the previous pick and
    // ahead of the best one found so far in this pass.
    assign cand_word = cmd.best_g ? g_word : f_word;
    assign cand_cnt  = cmd.best_g ? g_cnt  : f_cnt;
    assign cand_take = (cmd.best_f || cmd.best_g)
                    && (!prev_valid_reg || ahead(prev_cnt_reg, prev_word_reg, cand_cnt, cand_word))
                    && (!best_valid_reg || ahead(cand_cnt, cand_word, best_cnt_reg, best_word_reg));

    always_comb
    begin
        sel_char = 8'd0;
        for (int b = 0; b < WORD_BYTES; b++)
        begin
            if (int'(item_reg.read_pos) == b)
            begin
                sel_char = g_word[(WORD_BYTES - 1 - b) * 8 +: 8];
            end
        end
    end

    always_comb
    begin
        int unsigned effk;
        int unsigned fu;
        int unsigned gu;
        effk = (int'(topk_reg) > MAX_K) ? MAX_K : int'(topk_reg);
        fu   = int'(file_used_reg);
        gu   = int'(glob_used_reg);
        n_file = KW'((fu < effk) ? fu : effk);
        n_glob = KW'((gu < effk) ? gu : effk);
    end

    assign folded = ((item_reg.text_byte >= 8'h61) && (item_reg.text_byte <= 8'h7A))
                  ? (item_reg.text_byte - 8'h20) : item_reg.text_byte;

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topk_reg <= wftk_pkg::TOP_K_RESET;
        end
        else if (cfg_wr)
        begin
            topk_reg <= cfg_data;
        end
    end

    // The token is kept zero-padded so that it compares directly with rows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg     <= '0;
            tok_len_reg <= '0;
        end
        else if (cmd.tok_clear)
        begin
            tok_reg     <= '0;
            tok_len_reg <= '0;
        end
        else if (cmd.tok_append && (item_reg.text_byte != 8'd0)
                 && (int'(tok_len_reg) < WORD_BYTES - 1))
        begin
            tok_reg[(WORD_BYTES - 1 - int'(tok_len_reg)) * 8 +: 8] <= folded;
            tok_len_reg <= tok_len_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_used_reg    <= '0;
            glob_used_reg    <= '0;
            fidx_reg         <= '0;
            gidx_reg         <= '0;
            ovf_reg          <= 1'b0;
            best_valid_reg   <= 1'b0;
            prev_valid_reg   <= 1'b0;
            r_reg            <= '0;
            n_reg            <= '0;
            ranked_total_reg <= '0;
        end
        else
        begin
            if (cmd.f_idx_clr)
            begin
                fidx_reg <= '0;
            end
            else if (cmd.f_idx_inc)
            begin
                fidx_reg <= fidx_reg + FUW'(1);
            end

            if (cmd.g_idx_clr)
            begin
                gidx_reg <= '0;
            end
            else if (cmd.g_idx_inc)
            begin
                gidx_reg <= gidx_reg + GUW'(1);
            end

            if (cmd.f_used_clr)
            begin
                file_used_reg <= '0;
            end
            else if (cmd.f_add && !f_full)
            begin
                file_used_reg <= file_used_reg + FUW'(1);
            end

            if (cmd.g_add && !g_full)
            begin
                glob_used_reg <= glob_used_reg + GUW'(1);
            end

            if ((cmd.f_add && f_full) || (cmd.g_add && g_full))
            begin
                ovf_reg <= 1'b1;
            end

            if (cmd.best_clr)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (cand_take)
            begin
                best_valid_reg <= 1'b1;
            end

            if (cmd.rank_init_f || cmd.rank_init_g)
            begin
                r_reg          <= '0;
                prev_valid_reg <= 1'b0;
                n_reg          <= cmd.rank_init_g ? n_glob : n_file;
            end
            else if (cmd.rank_next)
            begin
                r_reg          <= r_reg + KW'(1);
                prev_valid_reg <= 1'b1;
            end

            if (cmd.ranked_set)
            begin
                ranked_total_reg <= n_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand_take)
        begin
            best_word_reg <= cand_word;
            best_cnt_reg  <= cand_cnt;
            best_gidx_reg <= gidx_reg[GAW-1:0];
        end
        if (cmd.rank_next)
        begin
            prev_word_reg <= best_word_reg;
            prev_cnt_reg  <= best_cnt_reg;
        end
        if (cmd.order_wr)
        begin
            order_reg[r_reg[KI-1:0]] <= best_gidx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_empty)
        begin
            res_status_reg <= wftk_pkg::ST_EMPTY;
            res_total_reg  <= '0;
            res_char_reg   <= 8'd0;
        end
        else if (cmd.res_plain)
        begin
            res_status_reg <= ovf_reg ? wftk_pkg::ST_OVERFLOW : wftk_pkg::ST_OK;
            res_total_reg  <= '0;
            res_char_reg   <= 8'd0;
        end
        else if (cmd.res_read)
        begin
            res_status_reg <= ovf_reg ? wftk_pkg::ST_OVERFLOW : wftk_pkg::ST_OK;
            res_total_reg  <= g_cnt;
            res_char_reg   <= sel_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.status      <= res_status_reg;
            out_reg.entry_count <= 5'(ranked_total_reg);
            out_reg.word_total  <= res_total_reg;
            out_reg.word_char   <= res_char_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign stat.action     = item_reg.action;
    assign stat.tok_empty  = (tok_len_reg == '0);
    assign stat.is_space   = is_ws(item_reg.text_byte);
    assign stat.f_scan_end = (fidx_reg == file_used_reg);
    assign stat.g_scan_end = (gidx_reg == glob_used_reg);
    assign stat.f_match    = (f_word == tok_reg);
    assign stat.g_match    = (g_word == best_word_reg);
    assign stat.r_done     = (r_reg == n_reg);
    assign stat.rank_empty = (32'(item_reg.read_rank) >= 32'(ranked_total_reg));
    assign stat.out_free   = !out_valid_reg || !out_stall;

    `WFTK_ASSERT_IMP(a_no_result_overwrite, clk, rst_n, cmd.out_load,
        !out_valid_reg || !out_stall)
    `WFTK_ASSERT_IMP(a_pick_exists, clk, rst_n, cmd.rank_next, best_valid_reg)
    `WFTK_ASSERT_IMP(a_order_in_table, clk, rst_n, cmd.order_wr,
        32'(best_gidx_reg) < 32'(glob_used_reg))
    `WFTK_ASSERT_NEXT(a_overflow_sticky, clk, rst_n, ovf_reg, ovf_reg)
    `WFTK_ASSERT_NEXT(a_token_cleared, clk, rst_n, cmd.tok_clear, tok_len_reg == '0)

endmodule

`default_nettype wire
